[src/prc_pkg.sv]
// prc_pkg: shared types, codes and constants for the pedigree relationship column block
// depends on nothing; used by the interfaces, the memories and the top level

package prc_pkg;

   localparam int IDX_W = 10;
   localparam int CNT_W = 11;
   localparam int F_W   = 31;
   localparam int W_W   = 32;
   localparam int P_W   = 63;

   // request codes
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_COMPUTE = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;
   localparam logic [1:0] REQ_NONE    = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_PARENT    = 2'd2;
   localparam logic [1:0] ST_NO_COLUMN = 2'd3;

   localparam logic [31:0] Q30_ONE            = 32'h4000_0000;
   localparam logic [31:0] Q30_HALF           = 32'h2000_0000;
   localparam logic [31:0] Q30_THREE_QUARTERS = 32'h3000_0000;
   localparam logic [31:0] Q28_ONE            = 32'h1000_0000;

   localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef struct packed {
      logic             known;
      logic [IDX_W-1:0] idx;
   } parent_type;

   typedef struct packed {
      parent_type     sire;
      parent_type     dam;
      logic [F_W-1:0] variance;
   } ped_entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      ped_entry_type    wr_data;
   } ped_ctl_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [F_W-1:0]   wr_data;
   } f_ctl_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [W_W-1:0]   wr_data;
   } col_ctl_type;

   // saturating add at 32 bits
   function automatic logic [W_W-1:0] sat_add(input logic [W_W-1:0] a,
                                              input logic [W_W:0] b);
      logic [W_W+1:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s[W_W+1:W_W] != 2'b00) ? {W_W{1'b1}} : s[W_W-1:0];
   endfunction

endpackage

[src/prc_if.sv]
// prc_if: handshake channels of the pedigree relationship column block
// depends on prc_pkg for field widths

interface prc_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [prc_pkg::IDX_W-1:0] entry_index;
   logic                      sire_known;
   logic [prc_pkg::IDX_W-1:0] sire_index;
   logic                      dam_known;
   logic [prc_pkg::IDX_W-1:0] dam_index;
   logic [prc_pkg::F_W-1:0]   inbreeding;

   modport source (output valid, req_type, entry_index, sire_known, sire_index,
                   dam_known, dam_index, inbreeding, input ready);
   modport sink (input valid, req_type, entry_index, sire_known, sire_index,
                 dam_known, dam_index, inbreeding, output ready);
endinterface

interface prc_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [prc_pkg::W_W-1:0] kinship;

   modport source (output valid, status, kinship, input ready);
   modport sink (input valid, status, kinship, output ready);
endinterface

interface prc_csr_if;
   logic                      valid;
   logic                      ready;
   logic [prc_pkg::CNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[src/pedigree_relationship_column.sv]
// pedigree_relationship_column: top level, request sequencer and output register
// depends on prc_pkg, prc_if, prc_ped_mem and prc_col_mem
//
// One item is handled at a time. A load makes one read of the parents'
// inbreeding and one write before its result moves into the output register.
// A compute for individual p clears the N entries in use, runs the upward
// halving (one column read, one parent read and two parent writes per entry),
// scales through the registered multiplier and ends with the downward pass;
// the column memory has a single write port. The result sits in an output
// register, so the next beat is taken while a result still waits on the
// response channel. The configuration port is always ready and must only be
// written while the block is idle.

module pedigree_relationship_column #(
   parameter int MAX_ENTRIES = 1024
) (
   input logic        clock,
   input logic        reset,
   prc_req_if.sink    req_chan,
   prc_rsp_if.source  rsp_chan,
   prc_csr_if.sink    csr_chan
);

   // entries beyond index 1023 can never be addressed
   localparam int LIM = (MAX_ENTRIES > 1024) ? 1024 : MAX_ENTRIES;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_CLEAR = 4'd3;
   localparam logic [3:0] S_UP0   = 4'd4;
   localparam logic [3:0] S_UP1   = 4'd5;
   localparam logic [3:0] S_UP2   = 4'd6;
   localparam logic [3:0] S_UP3   = 4'd7;
   localparam logic [3:0] S_SC0   = 4'd8;
   localparam logic [3:0] S_SC1   = 4'd9;
   localparam logic [3:0] S_SC2   = 4'd10;
   localparam logic [3:0] S_DN0   = 4'd11;
   localparam logic [3:0] S_DN1   = 4'd12;
   localparam logic [3:0] S_DN2   = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;

   logic [3:0]                   state_ff, state_in;
   logic [prc_pkg::IDX_W-1:0]    i_ff, i_in;
   logic [prc_pkg::IDX_W-1:0]    p_ff, p_in;
   prc_pkg::parent_type          ld_sire_ff, ld_sire_in;
   prc_pkg::parent_type          ld_dam_ff, ld_dam_in;
   logic [prc_pkg::F_W-1:0]      ld_f_ff, ld_f_in;
   prc_pkg::ped_entry_type       e_ff, e_in;
   logic [prc_pkg::W_W-1:0]      w_ff, w_in;
   logic [prc_pkg::W_W-1:0]      pend_ff, pend_in;
   logic [prc_pkg::P_W-1:0]      prod_ff, prod_in;
   logic [1:0]                   st_ff, st_in;
   logic [prc_pkg::W_W-1:0]      kin_ff, kin_in;
   logic                         col_ready_ff, col_ready_in;
   logic [prc_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [prc_pkg::W_W-1:0]      rsp_kinship_ff, rsp_kinship_in;

   prc_pkg::ped_ctl_type         ped_ctl;
   prc_pkg::f_ctl_type           f_ctl;
   prc_pkg::col_ctl_type         col_ctl;
   prc_pkg::ped_entry_type       ped_rd;
   logic [prc_pkg::F_W-1:0]      f_rd_a, f_rd_b;
   logic [prc_pkg::W_W-1:0]      col_rd_a, col_rd_b;

   logic [prc_pkg::CNT_W-1:0]    count_eff;
   logic                         req_fire;
   logic                         rsp_free;
   logic                         last_i;
   logic [prc_pkg::W_W-1:0]      half_w;
   logic [prc_pkg::W_W-1:0]      sire_new;
   logic [prc_pkg::W_W:0]        f_sum;
   logic [prc_pkg::W_W-1:0]      q_both, q_one;
   logic [prc_pkg::F_W-1:0]      f_one;
   logic [prc_pkg::F_W-1:0]      var_new;
   logic [prc_pkg::W_W:0]        inh_sum;
   logic [prc_pkg::W_W-1:0]      inh_s, inh_d;

   prc_ped_mem #(.DEPTH(LIM)) u_ped_mem (
      .clock   (clock),
      .ped_ctl (ped_ctl),
      .f_ctl   (f_ctl),
      .ped_rd  (ped_rd),
      .f_rd_a  (f_rd_a),
      .f_rd_b  (f_rd_b)
   );

   prc_col_mem #(.DEPTH(LIM)) u_col_mem (
      .clock    (clock),
      .col_ctl  (col_ctl),
      .col_rd_a (col_rd_a),
      .col_rd_b (col_rd_b)
   );

   // effective count, clamped at the memory depth
   assign count_eff = (count_ff > prc_pkg::CNT_W'(LIM)) ? prc_pkg::CNT_W'(LIM) : count_ff;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign last_i         = ({1'b0, i_ff} == (count_eff - prc_pkg::CNT_W'(1)));

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.kinship = rsp_kinship_ff;

   // segregation variance from the parents' inbreeding, clamped at zero
   always_comb begin
      f_sum  = {2'b00, f_rd_a} + {2'b00, f_rd_b};
      q_both = {1'b0, f_sum[prc_pkg::W_W:2]};
      f_one  = ld_sire_ff.known ? f_rd_a : f_rd_b;
      q_one  = {3'b000, f_one[prc_pkg::F_W-1:2]};
      if (ld_sire_ff.known && ld_dam_ff.known) begin
         var_new = (q_both >= prc_pkg::Q30_HALF) ? '0
                 : prc_pkg::F_W'(prc_pkg::Q30_HALF - q_both);
      end else if (ld_sire_ff.known || ld_dam_ff.known) begin
         var_new = (q_one >= prc_pkg::Q30_THREE_QUARTERS) ? '0
                 : prc_pkg::F_W'(prc_pkg::Q30_THREE_QUARTERS - q_one);
      end else begin
         var_new = prc_pkg::F_W'(prc_pkg::Q30_ONE);
      end
   end

   // upward pass: half of the current entry's value goes to each parent
   assign half_w   = {1'b0, w_ff[prc_pkg::W_W-1:1]};
   assign sire_new = prc_pkg::sat_add(col_rd_a, {1'b0, half_w});

   // downward pass: mean of the parents' values, unknown parent gives zero
   assign inh_s   = e_ff.sire.known ? col_rd_a : '0;
   assign inh_d   = e_ff.dam.known ? col_rd_b : '0;
   assign inh_sum = {1'b0, inh_s} + {1'b0, inh_d};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      p_in         = p_ff;
      ld_sire_in   = ld_sire_ff;
      ld_dam_in    = ld_dam_ff;
      ld_f_in      = ld_f_ff;
      e_in         = e_ff;
      w_in         = w_ff;
      pend_in      = pend_ff;
      prod_in      = prod_ff;
      st_in        = st_ff;
      kin_in       = kin_ff;
      col_ready_in = col_ready_ff;
      ped_ctl      = '0;
      f_ctl        = '0;
      col_ctl      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               st_in  = prc_pkg::ST_OK;
               kin_in = '0;
               p_in   = req_chan.entry_index;
               if (req_chan.req_type == prc_pkg::REQ_NONE) begin
                  state_in = S_FIN;
               end else if ({1'b0, req_chan.entry_index} >= count_eff) begin
                  st_in    = prc_pkg::ST_RANGE;
                  state_in = S_FIN;
               end else begin
                  case (req_chan.req_type)
                     prc_pkg::REQ_LOAD: begin
                        if ((req_chan.sire_known &&
                             req_chan.sire_index >= req_chan.entry_index) ||
                            (req_chan.dam_known &&
                             req_chan.dam_index >= req_chan.entry_index)) begin
                           st_in    = prc_pkg::ST_PARENT;
                           state_in = S_FIN;
                        end else begin
                           ld_sire_in.known = req_chan.sire_known;
                           ld_sire_in.idx   = req_chan.sire_known ? req_chan.sire_index : '0;
                           ld_dam_in.known  = req_chan.dam_known;
                           ld_dam_in.idx    = req_chan.dam_known ? req_chan.dam_index : '0;
                           ld_f_in          = req_chan.inbreeding;
                           f_ctl.rd_en      = 1'b1;
                           f_ctl.rd_addr_a  = req_chan.sire_index;
                           f_ctl.rd_addr_b  = req_chan.dam_index;
                           state_in         = S_LOAD;
                        end
                     end
                     prc_pkg::REQ_COMPUTE: begin
                        i_in     = '0;
                        state_in = S_CLEAR;
                     end
                     default: begin
                        if (!col_ready_ff) begin
                           st_in    = prc_pkg::ST_NO_COLUMN;
                           state_in = S_FIN;
                        end else begin
                           col_ctl.rd_en     = 1'b1;
                           col_ctl.rd_addr_a = req_chan.entry_index;
                           col_ctl.rd_addr_b = req_chan.entry_index;
                           state_in          = S_READ;
                        end
                     end
                  endcase
               end
            end
         end

         S_LOAD: begin
            ped_ctl.wr_en            = 1'b1;
            ped_ctl.wr_addr          = p_ff;
            ped_ctl.wr_data.sire     = ld_sire_ff;
            ped_ctl.wr_data.dam      = ld_dam_ff;
            ped_ctl.wr_data.variance = var_new;
            f_ctl.wr_en              = 1'b1;
            f_ctl.wr_addr            = p_ff;
            f_ctl.wr_data            = ld_f_ff;
            col_ready_in             = 1'b0;
            state_in                 = S_FIN;
         end

         S_READ: begin
            kin_in   = {1'b0, col_rd_a[prc_pkg::W_W-1:1]};
            state_in = S_FIN;
         end

         // zero the entries in use, seeding the individual with one
         S_CLEAR: begin
            col_ctl.wr_en   = 1'b1;
            col_ctl.wr_addr = i_ff;
            col_ctl.wr_data = (i_ff == p_ff) ? prc_pkg::Q28_ONE : '0;
            if (last_i) begin
               i_in     = p_ff;
               state_in = S_UP0;
            end else begin
               i_in = i_ff + prc_pkg::IDX_W'(1);
            end
         end

         S_UP0: begin
            col_ctl.rd_en     = 1'b1;
            col_ctl.rd_addr_a = i_ff;
            col_ctl.rd_addr_b = i_ff;
            ped_ctl.rd_en     = 1'b1;
            ped_ctl.rd_addr   = i_ff;
            state_in          = S_UP1;
         end

         S_UP1: begin
            w_in = col_rd_a;
            e_in = ped_rd;
            if (col_rd_a != '0 && (ped_rd.sire.known || ped_rd.dam.known)) begin
               col_ctl.rd_en     = 1'b1;
               col_ctl.rd_addr_a = ped_rd.sire.idx;
               col_ctl.rd_addr_b = ped_rd.dam.idx;
               state_in          = S_UP2;
            end else if (i_ff == '0) begin
               state_in = S_SC0;
            end else begin
               i_in     = i_ff - prc_pkg::IDX_W'(1);
               state_in = S_UP0;
            end
         end

         S_UP2: begin
            col_ctl.wr_en   = e_ff.sire.known;
            col_ctl.wr_addr = e_ff.sire.idx;
            col_ctl.wr_data = sire_new;
            // same parent on both sides takes the half twice
            if (e_ff.sire.known && e_ff.sire.idx == e_ff.dam.idx) begin
               pend_in = prc_pkg::sat_add(sire_new, {1'b0, half_w});
            end else begin
               pend_in = prc_pkg::sat_add(col_rd_b, {1'b0, half_w});
            end
            state_in = S_UP3;
         end

         S_UP3: begin
            col_ctl.wr_en   = e_ff.dam.known;
            col_ctl.wr_addr = e_ff.dam.idx;
            col_ctl.wr_data = pend_ff;
            if (i_ff == '0) begin
               state_in = S_SC0;
            end else begin
               i_in     = i_ff - prc_pkg::IDX_W'(1);
               state_in = S_UP0;
            end
         end

         S_SC0: begin
            col_ctl.rd_en     = 1'b1;
            col_ctl.rd_addr_a = i_ff;
            col_ctl.rd_addr_b = i_ff;
            ped_ctl.rd_en     = 1'b1;
            ped_ctl.rd_addr   = i_ff;
            state_in          = S_SC1;
         end

         S_SC1: begin
            prod_in  = prc_pkg::P_W'(col_rd_a) * prc_pkg::P_W'(ped_rd.variance);
            state_in = S_SC2;
         end

         S_SC2: begin
            col_ctl.wr_en   = 1'b1;
            col_ctl.wr_addr = i_ff;
            col_ctl.wr_data = prod_ff[61:30];
            if (i_ff == p_ff) begin
               i_in     = '0;
               state_in = S_DN0;
            end else begin
               i_in     = i_ff + prc_pkg::IDX_W'(1);
               state_in = S_SC0;
            end
         end

         S_DN0: begin
            col_ctl.rd_en     = 1'b1;
            col_ctl.rd_addr_a = i_ff;
            col_ctl.rd_addr_b = i_ff;
            ped_ctl.rd_en     = 1'b1;
            ped_ctl.rd_addr   = i_ff;
            state_in          = S_DN1;
         end

         S_DN1: begin
            w_in              = col_rd_a;
            e_in              = ped_rd;
            col_ctl.rd_en     = 1'b1;
            col_ctl.rd_addr_a = ped_rd.sire.idx;
            col_ctl.rd_addr_b = ped_rd.dam.idx;
            state_in          = S_DN2;
         end

         S_DN2: begin
            col_ctl.wr_en   = 1'b1;
            col_ctl.wr_addr = i_ff;
            col_ctl.wr_data = prc_pkg::sat_add(w_ff, {1'b0, inh_sum[prc_pkg::W_W:1]});
            if (last_i) begin
               col_ready_in = 1'b1;
               state_in     = S_FIN;
            end else begin
               i_in     = i_ff + prc_pkg::IDX_W'(1);
               state_in = S_DN0;
            end
         end

         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_kinship_in = rsp_kinship_ff;
      if (state_ff == S_FIN && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = st_ff;
         rsp_kinship_in = kin_ff;
      end
   end

   assign count_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ready_ff <= 1'b0;
         count_ff     <= prc_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ready_ff <= col_ready_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      p_ff           <= p_in;
      ld_sire_ff     <= ld_sire_in;
      ld_dam_ff      <= ld_dam_in;
      ld_f_ff        <= ld_f_in;
      e_ff           <= e_in;
      w_ff           <= w_in;
      pend_ff        <= pend_in;
      prod_ff        <= prod_in;
      st_ff          <= st_in;
      kin_ff         <= kin_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_kinship_ff <= rsp_kinship_in;
   end

   // a load write always leaves the column stale
   a_load_clears_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> !col_ready_ff)
      else $error("column still marked ready after a load");

   // a row read is only started with a valid column
   a_read_needs_column: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> col_ready_ff)
      else $error("row read without a computed column");

   // upward pass never climbs above the individual
   a_up_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP0) |-> (i_ff <= p_ff))
      else $error("upward pass index above the individual");

   // downward pass stays inside the entries in use
   a_down_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DN0) |-> ({1'b0, i_ff} < count_eff))
      else $error("downward pass index beyond the count");

   // a result only leaves the sequencer into a free output register
   a_fin_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result lost on hand-off");

endmodule

[src/prc_ped_mem.sv]
// prc_ped_mem: pedigree memory (parents and variance) and inbreeding memory
// depends on prc_pkg; reads are registered, inbreeding memory has two read ports

module prc_ped_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  prc_pkg::ped_ctl_type      ped_ctl,
   input  prc_pkg::f_ctl_type        f_ctl,
   output prc_pkg::ped_entry_type    ped_rd,
   output logic [prc_pkg::F_W-1:0]   f_rd_a,
   output logic [prc_pkg::F_W-1:0]   f_rd_b
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   prc_pkg::ped_entry_type    ped_mem [DEPTH];
   logic [prc_pkg::F_W-1:0]   f_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (ped_ctl.wr_en) begin
         ped_mem[ped_ctl.wr_addr[AW-1:0]] <= ped_ctl.wr_data;
      end
      if (ped_ctl.rd_en) begin
         ped_rd <= ped_mem[ped_ctl.rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (f_ctl.wr_en) begin
         f_mem[f_ctl.wr_addr[AW-1:0]] <= f_ctl.wr_data;
      end
      if (f_ctl.rd_en) begin
         f_rd_a <= f_mem[f_ctl.rd_addr_a[AW-1:0]];
         f_rd_b <= f_mem[f_ctl.rd_addr_b[AW-1:0]];
      end
   end

endmodule

[src/prc_col_mem.sv]
// prc_col_mem: relationship column working memory, two read ports and one write port
// depends on prc_pkg; reads are registered

module prc_col_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                    clock,
   input  prc_pkg::col_ctl_type    col_ctl,
   output logic [prc_pkg::W_W-1:0] col_rd_a,
   output logic [prc_pkg::W_W-1:0] col_rd_b
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [prc_pkg::W_W-1:0] col_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (col_ctl.wr_en) begin
         col_mem[col_ctl.wr_addr[AW-1:0]] <= col_ctl.wr_data;
      end
      if (col_ctl.rd_en) begin
         col_rd_a <= col_mem[col_ctl.rd_addr_a[AW-1:0]];
         col_rd_b <= col_mem[col_ctl.rd_addr_b[AW-1:0]];
      end
   end

endmodule
